/* design/bvpa_pkg.sv */
// ----------------------------------------------------------------------------
// bvpa_pkg
// Shared widths, command codes and controller/datapath bundles for the
// binned velocity profile average unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bvpa_pkg;

    localparam int BIN_COUNT = 32;
    localparam int BIN_W     = 5;
    localparam int VEL_W     = 16;
    localparam int NB_W      = 6;
    localparam int FA_W      = 9;
    localparam int MC_W      = 17;
    localparam int DROP_W    = 16;
    localparam int DIV_W     = 26;
    localparam int DVS_W     = 10;
    localparam int LANES     = 4;

    // Command codes carried in func
    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_CLOSE  = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_NUM_BINS = 1'b0;
    localparam logic CFG_FRAMES   = 1'b1;

    typedef logic [LANES-1:0][DIV_W-1:0] div_vec_t;

    // Controller to datapath
    typedef struct packed {
        logic             rd;
        logic             use_bin;
        logic [BIN_W-1:0] addr;
        logic             latch;
        logic             drop;
        logic             smp_wr;
        logic             cls_div;
        logic             rep_div;
        logic             cls_wr;
        logic             rep_load;
        logic             clr_frame;
        logic             clr_time;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic bin_ok;
        logic div_done;
        logic out_free;
        logic rep_empty;
        logic rep_last;
    } dp_stat_t;

endpackage

`default_nettype wire

/* design/bvpa_div.sv */
// ----------------------------------------------------------------------------
// bvpa_div
// Four-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module bvpa_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire bvpa_pkg::div_vec_t         dividend,
    input  wire logic [bvpa_pkg::DVS_W-1:0] divisor,
    output logic                            done,
    output bvpa_pkg::div_vec_t              quot
);
    import bvpa_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [DVS_W-1:0]             dvs_reg;
    div_vec_t                     quo_reg;
    div_vec_t                     quo_next;
    logic [LANES-1:0][DVS_W-1:0]  rem_reg;
    logic [LANES-1:0][DVS_W-1:0]  rem_next;

    // One restoring step per lane
    always_comb
    begin
        logic [DVS_W:0] trial;
        for (int i = 0; i < LANES; i++)
        begin
            trial = {rem_reg[i], quo_reg[i][DIV_W-1]};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial       = trial - {1'b0, dvs_reg};
                quo_next[i] = {quo_reg[i][DIV_W-2:0], 1'b1};
            end
            else
            begin
                quo_next[i] = {quo_reg[i][DIV_W-2:0], 1'b0};
            end
            rem_next[i] = trial[DVS_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

/* design/bvpa_dp.sv */
// ----------------------------------------------------------------------------
// bvpa_dp
// Datapath: configuration registers, frame and time stores, saturating
// arithmetic, shared divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bvpa_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bvpa_pkg::dp_cmd_t           cmd,
    output bvpa_pkg::dp_stat_t               stat,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_index,
    input  wire logic [bvpa_pkg::FA_W-1:0]   cfg_data,
    input  wire logic [15:0]                 y_pos,
    input  wire logic signed [15:0]          vel_x,
    input  wire logic signed [15:0]          vel_y,
    input  wire logic signed [15:0]          vel_z,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bvpa_pkg::BIN_W-1:0]       bin_index,
    output logic [bvpa_pkg::MC_W-1:0]        mean_count,
    output logic signed [15:0]               mean_vx,
    output logic signed [15:0]               mean_vy,
    output logic signed [15:0]               mean_vz,
    output logic [bvpa_pkg::DROP_W-1:0]      dropped_samples,
    output logic                             last_bin
);
    import bvpa_pkg::*;

    localparam logic signed [25:0] F_MAX = 26'sh1FFFFFF;
    localparam logic signed [25:0] F_MIN = -26'sh1FFFFFF - 26'sd1;
    localparam logic signed [27:0] T_MAX = 28'sd8388607;
    localparam logic signed [27:0] T_MIN = -28'sd8388608;
    localparam logic signed [26:0] O_MAX = 27'sd32767;
    localparam logic signed [26:0] O_MIN = -27'sd32768;
    localparam logic [9:0]  FC_MAX = 10'd1023;
    localparam logic [18:0] TC_MAX = 19'd262143;

    typedef struct packed {
        logic signed [25:0] sx;
        logic signed [25:0] sy;
        logic signed [25:0] sz;
        logic [9:0]         cnt;
    } frame_ent_t;

    typedef struct packed {
        logic signed [23:0] tx;
        logic signed [23:0] ty;
        logic signed [23:0] tz;
        logic [17:0]        tc;
    } time_ent_t;

    function automatic logic signed [25:0] fsum_add(input logic signed [25:0] a,
                                                    input logic signed [15:0] v);
        logic signed [26:0] s;
        s = 27'(a) + 27'(v);
        if (s > 27'(F_MAX))
            return F_MAX;
        else if (s < 27'(F_MIN))
            return F_MIN;
        else
            return s[25:0];
    endfunction

    function automatic logic signed [23:0] tsum_add(input logic signed [23:0] a,
                                                    input logic signed [26:0] m);
        logic signed [27:0] s;
        s = 28'(a) + 28'(m);
        if (s > T_MAX)
            return T_MAX[23:0];
        else if (s < T_MIN)
            return T_MIN[23:0];
        else
            return s[23:0];
    endfunction

    function automatic logic signed [15:0] osat(input logic signed [26:0] q);
        if (q > O_MAX)
            return O_MAX[15:0];
        else if (q < O_MIN)
            return O_MIN[15:0];
        else
            return q[15:0];
    endfunction

    function automatic logic [DIV_W-1:0] mag(input logic signed [25:0] v);
        return v[25] ? DIV_W'(-v) : DIV_W'(v);
    endfunction

    function automatic logic signed [26:0] apply_sign(input logic [DIV_W-1:0] q,
                                                      input logic neg);
        logic signed [26:0] p;
        p = $signed({1'b0, q});
        return neg ? -p : p;
    endfunction

    // Configuration and input latches
    logic [NB_W-1:0]    num_bins_reg;
    logic [FA_W-1:0]    frames_reg;
    logic [7:0]         bin_reg;
    logic signed [15:0] vx_reg, vy_reg, vz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg <= NB_W'(18);
            frames_reg   <= FA_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUM_BINS: num_bins_reg <= cfg_data[NB_W-1:0];
                CFG_FRAMES:   frames_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            bin_reg <= y_pos[15:8];
            vx_reg  <= vel_x;
            vy_reg  <= vel_y;
            vz_reg  <= vel_z;
        end
    end

    logic [BIN_W-1:0] addr;
    assign addr = cmd.use_bin ? bin_reg[BIN_W-1:0] : cmd.addr;

    // Stores with valid bits; an invalid entry reads as zero
    frame_ent_t frame_mem [BIN_COUNT];
    time_ent_t  time_mem  [BIN_COUNT];
    frame_ent_t frame_q;
    time_ent_t  time_q;
    logic       frame_qv_reg, time_qv_reg;
    logic [BIN_COUNT-1:0] frame_vld_reg, time_vld_reg;
    frame_ent_t frame_cur, frame_wr;
    time_ent_t  time_cur, time_wr;
    logic       frame_we, time_we;

    assign frame_cur = frame_qv_reg ? frame_q : '0;
    assign time_cur  = time_qv_reg  ? time_q  : '0;

    always_ff @(posedge clk)
    begin
        if (frame_we)
            frame_mem[addr] <= frame_wr;
        if (time_we)
            time_mem[addr] <= time_wr;
        if (cmd.rd)
        begin
            frame_q <= frame_mem[addr];
            time_q  <= time_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_vld_reg <= '0;
            time_vld_reg  <= '0;
            frame_qv_reg  <= 1'b0;
            time_qv_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.rd)
            begin
                frame_qv_reg <= frame_vld_reg[addr];
                time_qv_reg  <= time_vld_reg[addr];
            end
            if (cmd.clr_frame)
                frame_vld_reg <= '0;
            else if (frame_we)
                frame_vld_reg[addr] <= 1'b1;
            if (cmd.clr_time)
                time_vld_reg <= '0;
            else if (time_we)
                time_vld_reg[addr] <= 1'b1;
        end
    end

    // Sample accumulate
    logic bin_full;
    assign bin_full = (frame_cur.cnt >= FC_MAX);
    assign frame_we = cmd.smp_wr && !bin_full;

    always_comb
    begin
        frame_wr.sx  = fsum_add(frame_cur.sx, vx_reg);
        frame_wr.sy  = fsum_add(frame_cur.sy, vy_reg);
        frame_wr.sz  = fsum_add(frame_cur.sz, vz_reg);
        frame_wr.cnt = frame_cur.cnt + 10'd1;
    end

    // Divider operands and signs
    div_vec_t          div_a;
    logic [DVS_W-1:0]  div_d;
    logic              div_done;
    div_vec_t          quot;
    logic [2:0]        neg_reg;
    logic              zero_reg;

    always_comb
    begin
        if (cmd.rep_div)
        begin
            div_a[0] = {time_cur.tc, 8'd0};
            div_a[1] = mag(26'(time_cur.tx));
            div_a[2] = mag(26'(time_cur.ty));
            div_a[3] = mag(26'(time_cur.tz));
            div_d    = DVS_W'(frames_reg);
        end
        else
        begin
            div_a[0] = '0;
            div_a[1] = mag(frame_cur.sx);
            div_a[2] = mag(frame_cur.sy);
            div_a[3] = mag(frame_cur.sz);
            div_d    = frame_cur.cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rep_div)
        begin
            neg_reg  <= {time_cur.tz[23], time_cur.ty[23], time_cur.tx[23]};
            zero_reg <= (frames_reg == '0);
        end
        else if (cmd.cls_div)
        begin
            neg_reg  <= {frame_cur.sz[25], frame_cur.sy[25], frame_cur.sx[25]};
            zero_reg <= (frame_cur.cnt == '0);
        end
    end

    bvpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.cls_div || cmd.rep_div),
        .dividend (div_a),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (quot)
    );

    logic signed [26:0] qx, qy, qz;
    assign qx = zero_reg ? '0 : apply_sign(quot[1], neg_reg[0]);
    assign qy = zero_reg ? '0 : apply_sign(quot[2], neg_reg[1]);
    assign qz = zero_reg ? '0 : apply_sign(quot[3], neg_reg[2]);

    // Frame close into time sums
    logic [18:0] tc_sum;
    assign tc_sum  = {1'b0, time_cur.tc} + 19'(frame_cur.cnt);
    assign time_we = cmd.cls_wr;

    always_comb
    begin
        time_wr.tx = tsum_add(time_cur.tx, qx);
        time_wr.ty = tsum_add(time_cur.ty, qy);
        time_wr.tz = tsum_add(time_cur.tz, qz);
        time_wr.tc = (tc_sum > TC_MAX) ? TC_MAX[17:0] : tc_sum[17:0];
    end

    // Drop counter
    logic [DROP_W-1:0] drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drop_reg <= '0;
        else if (cmd.clr_time)
            drop_reg <= '0;
        else if ((cmd.drop || (cmd.smp_wr && bin_full)) && (drop_reg != '1))
            drop_reg <= drop_reg + 1'b1;
    end

    // Result register
    logic out_valid_reg;
    logic last;
    logic [MC_W-1:0] mc;
    assign last = ({1'b0, cmd.addr} == num_bins_reg - 1'b1) || (cmd.addr == '1);
    assign mc   = zero_reg ? '0 :
                  ((quot[0] > DIV_W'({MC_W{1'b1}})) ? '1 : quot[0][MC_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.rep_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rep_load)
        begin
            bin_index       <= cmd.addr;
            mean_count      <= mc;
            mean_vx         <= osat(qx);
            mean_vy         <= osat(qy);
            mean_vz         <= osat(qz);
            dropped_samples <= drop_reg;
            last_bin        <= last;
        end
    end

    assign out_valid = out_valid_reg;

    // Status
    assign stat.bin_ok    = (bin_reg < {2'b00, num_bins_reg}) && (bin_reg[7:BIN_W] == '0);
    assign stat.div_done  = div_done;
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.rep_empty = (num_bins_reg == '0);
    assign stat.rep_last  = last;

endmodule

`default_nettype wire

/* design/bvpa_ctrl.sv */
// ----------------------------------------------------------------------------
// bvpa_ctrl
// Controller: takes one transaction at a time and sequences sample
// accumulation, the frame-close bin walk and the report bin walk.
// ----------------------------------------------------------------------------
`default_nettype none

module bvpa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         func,
    input  wire bvpa_pkg::dp_stat_t stat,
    output bvpa_pkg::dp_cmd_t       cmd
);
    import bvpa_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_S_RD   = 4'd1;
    localparam logic [3:0] ST_S_WR   = 4'd2;
    localparam logic [3:0] ST_C_RD   = 4'd3;
    localparam logic [3:0] ST_C_DIV  = 4'd4;
    localparam logic [3:0] ST_C_WAIT = 4'd5;
    localparam logic [3:0] ST_C_WR   = 4'd6;
    localparam logic [3:0] ST_R_RD   = 4'd7;
    localparam logic [3:0] ST_R_DIV  = 4'd8;
    localparam logic [3:0] ST_R_WAIT = 4'd9;
    localparam logic [3:0] ST_R_OUT  = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [BIN_W-1:0] k_reg, k_next;
    logic             accept;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.addr   = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (accept)
                begin
                    cmd.latch = 1'b1;
                    priority case (func)
                        FUNC_SAMPLE: state_next = ST_S_RD;
                        FUNC_CLOSE:  state_next = ST_C_RD;
                        FUNC_REPORT:
                        begin
                            if (stat.rep_empty)
                                cmd.clr_time = 1'b1;
                            else
                                state_next = ST_R_RD;
                        end
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_S_RD:
            begin
                cmd.use_bin = 1'b1;
                if (stat.bin_ok)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_S_WR;
                end
                else
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_S_WR:
            begin
                cmd.use_bin = 1'b1;
                cmd.smp_wr  = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_C_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_C_DIV;
            end
            ST_C_DIV:
            begin
                cmd.cls_div = 1'b1;
                state_next  = ST_C_WAIT;
            end
            ST_C_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_C_WR;
            end
            ST_C_WR:
            begin
                cmd.cls_wr = 1'b1;
                k_next     = k_reg + 1'b1;
                if (k_reg == '1)
                begin
                    cmd.clr_frame = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_C_RD;
                end
            end
            ST_R_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_R_DIV;
            end
            ST_R_DIV:
            begin
                cmd.rep_div = 1'b1;
                state_next  = ST_R_WAIT;
            end
            ST_R_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_R_OUT;
            end
            ST_R_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.rep_load = 1'b1;
                    k_next       = k_reg + 1'b1;
                    if (stat.rep_last)
                    begin
                        cmd.clr_time = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_R_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

`default_nettype wire

/* design/binned_velocity_profile_average_unit.sv */
// ----------------------------------------------------------------------------
// binned_velocity_profile_average_unit
// Bins agent velocity samples by position, forms per-frame bin means and
// reports their time averages, one result per bin.
// ----------------------------------------------------------------------------
// Sample: store read, then read-modify-write; one transaction at a time.
// Close frame: walks all 32 bins in turn, one divide per bin on the
//   26-step shared divider.
// Report: walks the bins in use, one divide per bin, and waits on any output stall.
// Reset: all stores read as zero at once through valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module binned_velocity_profile_average_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  func,
    input  wire logic [15:0]                 y_pos,
    input  wire logic signed [15:0]          vel_x,
    input  wire logic signed [15:0]          vel_y,
    input  wire logic signed [15:0]          vel_z,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bvpa_pkg::BIN_W-1:0]       bin_index,
    output logic [bvpa_pkg::MC_W-1:0]        mean_count,
    output logic signed [15:0]               mean_vx,
    output logic signed [15:0]               mean_vy,
    output logic signed [15:0]               mean_vz,
    output logic [bvpa_pkg::DROP_W-1:0]      dropped_samples,
    output logic                             last_bin,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [bvpa_pkg::FA_W-1:0]   cfg_data
);
    import bvpa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    bvpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .stat     (stat),
        .cmd      (cmd)
    );

    bvpa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .y_pos           (y_pos),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .vel_z           (vel_z),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bin_index       (bin_index),
        .mean_count      (mean_count),
        .mean_vx         (mean_vx),
        .mean_vy         (mean_vy),
        .mean_vz         (mean_vz),
        .dropped_samples (dropped_samples),
        .last_bin        (last_bin)
    );

endmodule

`default_nettype wire

/* dv/binned_velocity_profile_average_unit_tb.sv */
// ----------------------------------------------------------------------------
// binned_velocity_profile_average_unit_tb
// Self-checking bench: a directed table of samples, frame closes and reports,
// a settings sweep, a receiver hold-off, a stretch with no idling on either
// side, then a random mix under several bin/frame settings. Every report
// result is checked against an in-bench profile predictor or a typed expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binned_velocity_profile_average_unit_tb;

    import bvpa_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 1500;     // covers a full close-frame walk
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [MC_W-1:0]   cnt;
        logic [15:0]       vx;
        logic [15:0]       vy;
        logic [15:0]       vz;
        logic [DROP_W-1:0] drops;
        logic              last;
    } bin_result_t;

    typedef struct {
        logic [1:0]  f;
        logic [15:0] y;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        bit          typed;
        int          drops;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] func = '0;
    logic [15:0] y_pos = '0;
    logic signed [15:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [BIN_W-1:0] bin_index;
    logic [MC_W-1:0] mean_count;
    logic signed [15:0] mean_vx, mean_vy, mean_vz;
    logic [DROP_W-1:0] dropped_samples;
    logic last_bin;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [FA_W-1:0] cfg_data = '0;

    binned_velocity_profile_average_unit dut (.*);

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state
    longint nbins_cfg, frames_cfg;
    longint fsum_x[BIN_COUNT], fsum_y[BIN_COUNT], fsum_z[BIN_COUNT];
    longint fcount[BIN_COUNT];
    longint tsum_x[BIN_COUNT], tsum_y[BIN_COUNT], tsum_z[BIN_COUNT];
    longint tcount[BIN_COUNT];
    longint drop_total;

    bin_result_t pending_bins[$];
    stim_row_t   table_rows[$];
    int  errors = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;
    longint cycles = 0;

    function automatic longint clamp_s(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Profile predictor: one accepted transaction, results pushed if emit
    function automatic void profile_step(logic [1:0] f, logic [15:0] y,
                                         logic signed [15:0] vx,
                                         logic signed [15:0] vy,
                                         logic signed [15:0] vz, bit emit);
        longint b, n, mx, my, mz, nb, mc;
        bin_result_t r;
        case (f)
            FUNC_SAMPLE:
            begin
                b = y >> 8;
                if (b >= nbins_cfg || b >= BIN_COUNT || fcount[b] >= 1023)
                begin
                    if (drop_total < 65535) drop_total++;
                end
                else
                begin
                    fsum_x[b] = clamp_s(fsum_x[b] + longint'(vx), 26);
                    fsum_y[b] = clamp_s(fsum_y[b] + longint'(vy), 26);
                    fsum_z[b] = clamp_s(fsum_z[b] + longint'(vz), 26);
                    fcount[b]++;
                end
            end
            FUNC_CLOSE:
            begin
                for (int k = 0; k < BIN_COUNT; k++)
                begin
                    n = fcount[k];
                    mx = 0; my = 0; mz = 0;
                    if (n != 0)
                    begin
                        mx = fsum_x[k] / n;
                        my = fsum_y[k] / n;
                        mz = fsum_z[k] / n;
                    end
                    tsum_x[k] = clamp_s(tsum_x[k] + mx, 24);
                    tsum_y[k] = clamp_s(tsum_y[k] + my, 24);
                    tsum_z[k] = clamp_s(tsum_z[k] + mz, 24);
                    tcount[k] = (tcount[k] + n > 262143) ? 262143 : tcount[k] + n;
                    fsum_x[k] = 0; fsum_y[k] = 0; fsum_z[k] = 0; fcount[k] = 0;
                end
            end
            FUNC_REPORT:
            begin
                nb = (nbins_cfg > BIN_COUNT) ? BIN_COUNT : nbins_cfg;
                for (int k = 0; k < nb; k++)
                begin
                    r = '0;
                    r.bin = k[BIN_W-1:0];
                    if (frames_cfg != 0)
                    begin
                        mc = (tcount[k] << 8) / frames_cfg;
                        r.cnt = (mc > 131071) ? 17'h1FFFF : mc[16:0];
                        r.vx = 16'(clamp_s(tsum_x[k] / frames_cfg, 16));
                        r.vy = 16'(clamp_s(tsum_y[k] / frames_cfg, 16));
                        r.vz = 16'(clamp_s(tsum_z[k] / frames_cfg, 16));
                    end
                    r.drops = drop_total[15:0];
                    r.last = (k == nb - 1);
                    if (emit) pending_bins.push_back(r);
                    tsum_x[k] = 0; tsum_y[k] = 0; tsum_z[k] = 0; tcount[k] = 0;
                end
                for (int k = 0; k < BIN_COUNT; k++)
                begin
                    tsum_x[k] = 0; tsum_y[k] = 0; tsum_z[k] = 0; tcount[k] = 0;
                end
                drop_total = 0;
            end
            default: ;
        endcase
    endfunction

    // Typed expectation: report of an empty history, only the drop count set
    function automatic void push_zero_report(int drops);
        longint nb;
        bin_result_t r;
        nb = (nbins_cfg > BIN_COUNT) ? BIN_COUNT : nbins_cfg;
        for (int k = 0; k < nb; k++)
        begin
            r = '0;
            r.bin = k[BIN_W-1:0];
            r.drops = drops[15:0];
            r.last = (k == nb - 1);
            pending_bins.push_back(r);
        end
    endfunction

    // Offer one transaction, hold it until accepted
    task automatic send_item(logic [1:0] f, logic [15:0] y, logic [15:0] vx,
                             logic [15:0] vy, logic [15:0] vz,
                             bit typed = 1'b0, int drops = 0);
        int gap;
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 32)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        y_pos <= y;
        vel_x <= vx;
        vel_y <= vy;
        vel_z <= vz;
        do @(posedge clk); while (!(in_valid && in_ready));
        if (typed)
        begin
            push_zero_report(drops);
            profile_step(f, y, vx, vy, vz, 1'b0);
        end
        else
            profile_step(f, y, vx, vy, vz, 1'b1);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_bins.size() != 0) @(negedge clk);
    endtask

    // Register write while idle, after close-frame work has run out
    task automatic write_reg(logic idx, logic [FA_W-1:0] data);
        stop_sending();
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        if (idx == CFG_NUM_BINS) nbins_cfg = data & 9'h3F;
        else frames_cfg = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(logic [1:0] f, logic [15:0] y, logic [15:0] vx,
                           logic [15:0] vy, logic [15:0] vz,
                           bit typed = 1'b0, int drops = 0);
        stim_row_t r;
        r.f = f; r.y = y; r.vx = vx; r.vy = vy; r.vz = vz;
        r.typed = typed; r.drops = drops;
        table_rows.push_back(r);
    endtask

    task automatic random_phase(int count);
        int sel;
        logic [15:0] y;
        logic [1:0] f;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 78) f = FUNC_SAMPLE;
            else if (sel < 90) f = FUNC_CLOSE;
            else if (sel < 96) f = FUNC_REPORT;
            else f = FUNC_UNUSED;
            if ($urandom_range(99) < 75)
                y = {8'($urandom_range(0, 33)), 8'($urandom)};
            else
                y = 16'($urandom);
            send_item(f, y, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        send_item(FUNC_CLOSE, '0, '0, '0, '0);
        send_item(FUNC_REPORT, '0, '0, '0, '0);
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 1'b0;
        end
        else
            out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        bin_result_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{bin_index, mean_count, mean_vx, mean_vy, mean_vz,
                    dropped_samples, last_bin};
            if (pending_bins.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result bin=%0d", $realtime, bin_index);
            end
            else
            begin
                want = pending_bins.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: expected bin=%0d cnt=%0d vx=%0d vy=%0d vz=%0d drop=%0d last=%0b",
                             $realtime, want.bin, want.cnt, $signed(want.vx),
                             $signed(want.vy), $signed(want.vz), want.drops, want.last);
                    $display("%0t: actual   bin=%0d cnt=%0d vx=%0d vy=%0d vz=%0d drop=%0d last=%0b",
                             $realtime, got.bin, got.cnt, $signed(got.vx),
                             $signed(got.vy), $signed(got.vz), got.drops, got.last);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("binned_velocity_profile_average_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        nbins_cfg = 18;
        frames_cfg = 1;
        drop_total = 0;
        for (int k = 0; k < BIN_COUNT; k++)
        begin
            fsum_x[k] = 0; fsum_y[k] = 0; fsum_z[k] = 0; fcount[k] = 0;
            tsum_x[k] = 0; tsum_y[k] = 0; tsum_z[k] = 0; tcount[k] = 0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        add_row(FUNC_REPORT, '0, '0, '0, '0, 1'b1, 0);         // empty after reset
        add_row(FUNC_SAMPLE, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF); // bin out of range
        add_row(FUNC_SAMPLE, 16'h1200, 16'h0001, 16'h0001, 16'h0001); // bin == num_bins
        add_row(FUNC_REPORT, '0, '0, '0, '0, 1'b1, 2);
        add_row(FUNC_UNUSED, 16'h0100, 16'h1234, 16'h1234, 16'h1234);
        add_row(FUNC_SAMPLE, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000);
        add_row(FUNC_SAMPLE, 16'h00FF, 16'h8000, 16'h7FFF, 16'hFFFF);
        add_row(FUNC_SAMPLE, 16'h11FF, 16'h0001, 16'hFFFF, 16'h7FFF);
        add_row(FUNC_SAMPLE, 16'h0500, 16'hFFF9, 16'h0007, 16'h0003);
        add_row(FUNC_SAMPLE, 16'h0580, 16'h0002, 16'h0002, 16'hFFFE);
        add_row(FUNC_SAMPLE, 16'h0540, 16'h0000, 16'h0000, 16'h0000);
        add_row(FUNC_CLOSE, '0, '0, '0, '0);
        add_row(FUNC_CLOSE, '0, '0, '0, '0);                    // empty frame
        add_row(FUNC_SAMPLE, 16'h0A00, 16'h0100, 16'hFF00, 16'h0080);
        add_row(FUNC_CLOSE, '0, '0, '0, '0);
        add_row(FUNC_REPORT, '0, '0, '0, '0);
        foreach (table_rows[i])
            send_item(table_rows[i].f, table_rows[i].y, table_rows[i].vx,
                      table_rows[i].vy, table_rows[i].vz,
                      table_rows[i].typed, table_rows[i].drops);

        // Settings sweep with short checks
        write_reg(CFG_NUM_BINS, 9'd32);
        write_reg(CFG_FRAMES, 9'd256);
        for (int i = 0; i < 8; i++)
            send_item(FUNC_SAMPLE, {8'(i * 4 + 3), 8'($urandom)},
                      16'($urandom), 16'($urandom), 16'($urandom));
        send_item(FUNC_CLOSE, '0, '0, '0, '0);
        send_item(FUNC_REPORT, '0, '0, '0, '0);
        write_reg(CFG_FRAMES, 9'd0);                             // zero divisor
        send_item(FUNC_SAMPLE, 16'h0200, 16'h0400, 16'h0400, 16'h0400);
        send_item(FUNC_CLOSE, '0, '0, '0, '0);
        send_item(FUNC_REPORT, '0, '0, '0, '0);
        write_reg(CFG_NUM_BINS, 9'd0);                           // zero bins
        send_item(FUNC_SAMPLE, 16'h0000, 16'h0400, 16'h0400, 16'h0400);
        send_item(FUNC_REPORT, '0, '0, '0, '0);
        write_reg(CFG_NUM_BINS, 9'h1FF);                         // too many bins
        write_reg(CFG_FRAMES, 9'd1);
        send_item(FUNC_SAMPLE, 16'h1F00, 16'h0400, 16'h0400, 16'h0400);
        send_item(FUNC_SAMPLE, 16'h2000, 16'h0400, 16'h0400, 16'h0400);
        send_item(FUNC_CLOSE, '0, '0, '0, '0);
        send_item(FUNC_REPORT, '0, '0, '0, '0);

        // Receiver holds off while samples and a report pile up
        stop_sending();
        drain();
        hold_req = 1'b1;
        send_item(FUNC_REPORT, '0, '0, '0, '0);
        for (int i = 0; i < 6; i++)
            send_item(FUNC_SAMPLE, 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
        send_item(FUNC_REPORT, '0, '0, '0, '0);
        // Sender waits for every result before going on
        stop_sending();
        drain();

        // Stretch with no idling on either side
        no_idle = 1'b1;
        write_reg(CFG_NUM_BINS, 9'd32);
        random_phase(40);
        no_idle = 1'b0;

        // Random part across settings
        random_phase(40);
        write_reg(CFG_NUM_BINS, 9'd32);
        write_reg(CFG_FRAMES, 9'd3);
        random_phase(45);
        write_reg(CFG_NUM_BINS, 9'd1);
        write_reg(CFG_FRAMES, 9'd256);
        random_phase(30);
        write_reg(CFG_NUM_BINS, 9'(1 + $urandom_range(30)));
        write_reg(CFG_FRAMES, 9'($urandom_range(1, 255)));
        random_phase(40);
        write_reg(CFG_NUM_BINS, 9'd18);
        write_reg(CFG_FRAMES, 9'd1);
        random_phase(40);
        stop_sending();

        // Wind down
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_bins.size() == 0)
            $display("binned_velocity_profile_average_unit: match");
        else
            $display("binned_velocity_profile_average_unit: mismatch");
        $finish;
    end

endmodule
